// ===== sv/point_rotate_about_origin_top_macros.svh =====
// assertion macros used by the checker of the point rotation block
// depends on nothing; each macro expands to one labeled concurrent assertion
`ifndef POINT_ROTATE_ABOUT_ORIGIN_TOP_MACROS_SVH
`define POINT_ROTATE_ABOUT_ORIGIN_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pra_pkg.sv =====
// constants and tables for the point rotation block
// no dependencies; used by the top level, its checker and the testbench
`timescale 1ns / 1ps

package pra_pkg;

   localparam int COORD_WIDTH_DEF   = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   // coordinate width plus guard bits is always this many bits
   localparam int SCALED_BITS = 36;

   localparam int ANGLE_WIDTH = 16;
   localparam int BANG_WIDTH  = 32;

   // angle to binary angle: a * 2^32 / 23040 = a * 2^23 / 45
   localparam int ANGLE_DIV    = 45;
   localparam int FRAC_SHIFT   = 23;
   localparam int QUO_WIDTH    = 10;
   localparam int REM_WIDTH    = 6;
   localparam int FRAC_WIDTH   = 23;
   localparam int RECIP_SHIFT  = 21;
   localparam logic [ANGLE_WIDTH-1:0] DIV45_RECIP = 16'd46604;

   // cordic gain correction, 0.6072529350 in q24
   localparam int GAIN_WIDTH = 24;
   localparam logic [GAIN_WIDTH-1:0] GAIN_Q24 = 24'd10188014;

   localparam int ATAN_LEN = 24;
   localparam logic [BANG_WIDTH-1:0] ATAN_TBL [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic [FRAC_WIDTH-1:0] frac_tbl_type [ANGLE_DIV];

   // rounded binary-angle fraction for each remainder of the divide by 45
   function automatic frac_tbl_type build_frac_tbl();
      frac_tbl_type t;
      longint       num;
      for (int r = 0; r < ANGLE_DIV; r++) begin
         num  = (longint'(r) <<< FRAC_SHIFT) + 22;
         t[r] = FRAC_WIDTH'(num / ANGLE_DIV);
      end
      return t;
   endfunction

   localparam frac_tbl_type FRAC_TBL = build_frac_tbl();

endpackage

// ===== sv/point_rotate_about_origin_top.sv =====
// point rotation about a pivot: pipelined cordic with gain correction
// depends on pra_pkg
`timescale 1ns / 1ps

// Rotates a Q16.8 point counterclockwise about a Q16.8 pivot by a signed
// angle in 1/64 degree units (wraps modulo one turn). The block takes one
// beat per clock while req_stall is low and returns one beat per item, in
// order. The divide, remainder, binary-angle and fold stages turn the
// angle into a binary angle and fold it into +-90 degrees, one cordic
// iteration sits in each of the next CORDIC_STAGES stages, then come the
// split gain multiply, the rounding shift and the pivot add with
// saturation. Every stage has its own valid bit and moves
// on when the stage after it is empty or moving, so empty slots close up
// under a stall and req_stall rises only once every stage holds an item
// and rsp_stall is high. A point equal to its pivot, or a zero angle,
// comes back unchanged; all other results saturate to the coordinate range.
module point_rotate_about_origin_top #(
   parameter int COORD_WIDTH   = pra_pkg::COORD_WIDTH_DEF,
   parameter int CORDIC_STAGES = pra_pkg::CORDIC_STAGES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_point_x,
   input  logic signed [COORD_WIDTH-1:0]          req_point_y,
   input  logic signed [COORD_WIDTH-1:0]          req_pivot_x,
   input  logic signed [COORD_WIDTH-1:0]          req_pivot_y,
   input  logic signed [pra_pkg::ANGLE_WIDTH-1:0] req_angle_deg,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [COORD_WIDTH-1:0]          rsp_rotated_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_rotated_y
);

   // widths
   localparam int CW    = COORD_WIDTH;
   localparam int N     = CORDIC_STAGES;
   localparam int GUARD = pra_pkg::SCALED_BITS - CW;
   localparam int XW    = CW + GUARD + 4;           // cordic x/y, covers gain growth
   localparam int ZW    = pra_pkg::BANG_WIDTH + 2;  // residual angle
   localparam int ML    = XW / 2;                   // low half of the split multiply
   localparam int MLW   = ML + pra_pkg::GAIN_WIDTH;
   localparam int MHW   = XW - ML + pra_pkg::GAIN_WIDTH + 1;
   localparam int PW    = XW + pra_pkg::GAIN_WIDTH + 1;
   localparam int SH    = pra_pkg::GAIN_WIDTH + GUARD;
   localparam int RW    = XW - GUARD;
   localparam int AW    = pra_pkg::ANGLE_WIDTH;
   localparam int BW    = pra_pkg::BANG_WIDTH;

   // stage positions
   localparam int ST_DIV  = 0;
   localparam int ST_REM  = 1;
   localparam int ST_BANG = 2;
   localparam int ST_FOLD = 3;
   localparam int ST_MULT = N + 4;
   localparam int ST_RND  = N + 5;
   localparam int ST_OUT  = N + 6;
   localparam int NS      = N + 7;

   localparam logic signed [ZW-1:0]  QUARTER   = ZW'(64'sd1 <<< (BW - 2));
   localparam logic signed [ZW-1:0]  HALF_TURN = ZW'(64'sd1 <<< (BW - 1));
   localparam logic signed [MHW-1:0] GAIN_S    = MHW'({1'b0, pra_pkg::GAIN_Q24});
   localparam logic [MLW-1:0]        GAIN_U    = MLW'(pra_pkg::GAIN_Q24);
   localparam logic signed [PW-1:0]  RND_HALF  = PW'(64'sd1 <<< (SH - 1));
   localparam logic signed [RW:0]    SAT_MAX   = (RW+1)'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [RW:0]    SAT_MIN   = (RW+1)'(-(64'sd1 <<< (CW - 1)));
   localparam logic [AW-1:0]         DIV_CONST = AW'(pra_pkg::ANGLE_DIV);

   // fields that ride along to the last stage
   typedef struct packed {
      logic                 byp;
      logic signed [CW-1:0] px;
      logic signed [CW-1:0] py;
      logic signed [CW-1:0] ox;
      logic signed [CW-1:0] oy;
   } pass_type;

   typedef struct packed {
      pass_type                         ps;
      logic                             neg;
      logic [AW-1:0]                    mag;
      logic [pra_pkg::QUO_WIDTH-1:0]    quo;
      logic signed [CW:0]               dx;
      logic signed [CW:0]               dy;
   } div_type;

   typedef struct packed {
      pass_type                         ps;
      logic                             neg;
      logic [pra_pkg::QUO_WIDTH-1:0]    quo;
      logic [pra_pkg::REM_WIDTH-1:0]    rem;
      logic signed [CW:0]               dx;
      logic signed [CW:0]               dy;
   } rem_type;

   typedef struct packed {
      pass_type           ps;
      logic [BW-1:0]      ang;
      logic signed [CW:0] dx;
      logic signed [CW:0] dy;
   } bang_type;

   typedef struct packed {
      pass_type           ps;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } cord_type;

   typedef struct packed {
      pass_type              ps;
      logic [MLW-1:0]        xl;
      logic [MLW-1:0]        yl;
      logic signed [MHW-1:0] xh;
      logic signed [MHW-1:0] yh;
   } mult_type;

   typedef struct packed {
      pass_type             ps;
      logic signed [RW-1:0] x;
      logic signed [RW-1:0] y;
   } rnd_type;

   // flow control: a stage moves when it is empty or the next one moves
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   assign adv[NS] = !rsp_stall;
   for (genvar i = 0; i < NS; i++) begin : g_adv
      assign adv[i] = !vld_ff[i] || adv[i+1];
   end

   assign vld_in = (adv[NS-1:0] & {vld_ff[NS-2:0], req_valid}) | (~adv[NS-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[ST_OUT];

   // stage: offsets, angle magnitude, quotient estimate by 45
   div_type                 div_ff, div_in;
   logic [2*AW-1:0]         recip_prod;

   always_comb begin
      div_in.ps.byp = ((req_point_x == req_pivot_x) && (req_point_y == req_pivot_y))
                      || (req_angle_deg == '0);
      div_in.ps.px  = req_point_x;
      div_in.ps.py  = req_point_y;
      div_in.ps.ox  = req_pivot_x;
      div_in.ps.oy  = req_pivot_y;
      div_in.neg    = req_angle_deg[AW-1];
      div_in.mag    = req_angle_deg[AW-1] ? AW'(-req_angle_deg) : AW'(req_angle_deg);
      recip_prod    = div_in.mag * pra_pkg::DIV45_RECIP;
      div_in.quo    = recip_prod[pra_pkg::RECIP_SHIFT +: pra_pkg::QUO_WIDTH];
      div_in.dx     = (CW+1)'(req_point_x) - (CW+1)'(req_pivot_x);
      div_in.dy     = (CW+1)'(req_point_y) - (CW+1)'(req_pivot_y);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_DIV]) begin
         div_ff <= div_in;
      end
   end

   // stage: remainder with one correction step
   rem_type       rem_ff, rem_in;
   logic [AW-1:0] rem_raw;

   always_comb begin
      rem_in.ps  = div_ff.ps;
      rem_in.neg = div_ff.neg;
      rem_in.dx  = div_ff.dx;
      rem_in.dy  = div_ff.dy;
      rem_raw    = div_ff.mag - AW'(div_ff.quo) * DIV_CONST;
      if (rem_raw >= DIV_CONST) begin
         rem_in.quo = div_ff.quo + 1'b1;
         rem_in.rem = pra_pkg::REM_WIDTH'(rem_raw - DIV_CONST);
      end else begin
         rem_in.quo = div_ff.quo;
         rem_in.rem = pra_pkg::REM_WIDTH'(rem_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_REM]) begin
         rem_ff <= rem_in;
      end
   end

   // stage: binary angle, wraps modulo one turn
   bang_type      bang_ff, bang_in;
   logic [BW-1:0] bang_mag;

   always_comb begin
      bang_in.ps  = rem_ff.ps;
      bang_in.dx  = rem_ff.dx;
      bang_in.dy  = rem_ff.dy;
      bang_mag    = (BW'(rem_ff.quo) << pra_pkg::FRAC_SHIFT)
                    + BW'(pra_pkg::FRAC_TBL[rem_ff.rem]);
      bang_in.ang = rem_ff.neg ? -bang_mag : bang_mag;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_BANG]) begin
         bang_ff <= bang_in;
      end
   end

   // stage: scale offsets, fold angle into +-90 degrees
   cord_type cd_ff [N+1];
   cord_type fold_in;
   logic signed [ZW-1:0] fold_z;
   logic signed [XW-1:0] fold_x, fold_y;

   always_comb begin
      fold_in.ps = bang_ff.ps;
      fold_z     = ZW'($signed(bang_ff.ang));
      fold_x     = XW'(bang_ff.dx) <<< GUARD;
      fold_y     = XW'(bang_ff.dy) <<< GUARD;
      if (fold_z > QUARTER) begin
         fold_in.z = fold_z - HALF_TURN;
         fold_in.x = -fold_x;
         fold_in.y = -fold_y;
      end else if (fold_z < -QUARTER) begin
         fold_in.z = fold_z + HALF_TURN;
         fold_in.x = -fold_x;
         fold_in.y = -fold_y;
      end else begin
         fold_in.z = fold_z;
         fold_in.x = fold_x;
         fold_in.y = fold_y;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_FOLD]) begin
         cd_ff[0] <= fold_in;
      end
   end

   // cordic iterations, one per stage; iteration k-1 uses shift k-1
   for (genvar k = 1; k <= N; k++) begin : g_cordic
      cord_type             cd_in;
      logic signed [XW-1:0] xs, ys;
      logic signed [ZW-1:0] atan;

      always_comb begin
         cd_in.ps = cd_ff[k-1].ps;
         xs       = cd_ff[k-1].x >>> (k - 1);
         ys       = cd_ff[k-1].y >>> (k - 1);
         atan     = ZW'(pra_pkg::ATAN_TBL[k-1]);
         if (!cd_ff[k-1].z[ZW-1]) begin
            cd_in.x = cd_ff[k-1].x - ys;
            cd_in.y = cd_ff[k-1].y + xs;
            cd_in.z = cd_ff[k-1].z - atan;
         end else begin
            cd_in.x = cd_ff[k-1].x + ys;
            cd_in.y = cd_ff[k-1].y - xs;
            cd_in.z = cd_ff[k-1].z + atan;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[ST_FOLD + k]) begin
            cd_ff[k] <= cd_in;
         end
      end
   end

   // gain multiply, split into low and high halves
   mult_type mult_ff, mult_in;

   always_comb begin
      mult_in.ps = cd_ff[N].ps;
      mult_in.xl = MLW'(cd_ff[N].x[ML-1:0]) * GAIN_U;
      mult_in.yl = MLW'(cd_ff[N].y[ML-1:0]) * GAIN_U;
      mult_in.xh = MHW'($signed(cd_ff[N].x[XW-1:ML])) * GAIN_S;
      mult_in.yh = MHW'($signed(cd_ff[N].y[XW-1:ML])) * GAIN_S;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_MULT]) begin
         mult_ff <= mult_in;
      end
   end

   // join halves, round half up, drop guard and gain fraction bits
   rnd_type              rnd_ff, rnd_in;
   logic signed [PW-1:0] sum_x, sum_y;

   always_comb begin
      rnd_in.ps = mult_ff.ps;
      sum_x     = (PW'(mult_ff.xh) <<< ML) + PW'(mult_ff.xl) + RND_HALF;
      sum_y     = (PW'(mult_ff.yh) <<< ML) + PW'(mult_ff.yl) + RND_HALF;
      rnd_in.x  = RW'(sum_x >>> SH);
      rnd_in.y  = RW'(sum_y >>> SH);
   end

   always_ff @(posedge clock) begin
      if (adv[ST_RND]) begin
         rnd_ff <= rnd_in;
      end
   end

   // pivot add, saturate, pass-through for the unchanged cases
   logic signed [CW-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [RW:0]   abs_x, abs_y;

   always_comb begin
      abs_x = (RW+1)'(rnd_ff.x) + (RW+1)'(rnd_ff.ps.ox);
      abs_y = (RW+1)'(rnd_ff.y) + (RW+1)'(rnd_ff.ps.oy);
      if (rnd_ff.ps.byp) begin
         out_x_in = rnd_ff.ps.px;
      end else if (abs_x > SAT_MAX) begin
         out_x_in = CW'(SAT_MAX);
      end else if (abs_x < SAT_MIN) begin
         out_x_in = CW'(SAT_MIN);
      end else begin
         out_x_in = CW'(abs_x);
      end
      if (rnd_ff.ps.byp) begin
         out_y_in = rnd_ff.ps.py;
      end else if (abs_y > SAT_MAX) begin
         out_y_in = CW'(SAT_MAX);
      end else if (abs_y < SAT_MIN) begin
         out_y_in = CW'(SAT_MIN);
      end else begin
         out_y_in = CW'(abs_y);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign rsp_rotated_x = out_x_ff;
   assign rsp_rotated_y = out_y_ff;

endmodule

// ===== sv/pra_checker.sv =====
// port-level checks for the point rotation block, bound to its top level
// depends on pra_pkg and point_rotate_about_origin_top_macros.svh
`timescale 1ns / 1ps

`include "point_rotate_about_origin_top_macros.svh"

module pra_checker #(
   parameter int COORD_WIDTH = pra_pkg::COORD_WIDTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_WIDTH-1:0] rsp_rotated_x,
   input logic signed [COORD_WIDTH-1:0] rsp_rotated_y
);

   // a stalled result beat stays and holds its payload
   `PRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rotated_x) && $stable(rsp_rotated_y), "stalled result beat changed")

   // pipeline comes out of reset empty
   `PRA_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid, "result beat right after reset")

   // input back-pressure only when the result side is blocked
   `PRA_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "input stalled with result side free")

endmodule

bind point_rotate_about_origin_top pra_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pra_checker (.*);

// ===== test/tb_top.sv =====
// self-checking testbench for the point rotation block: a directed table of beats, then
// random beats, each result compared with its typed answer or an in-bench cordic model
// depends on pra_pkg and point_rotate_about_origin_top
`timescale 1ns / 1ps

module tb_top;

   localparam int COORD_W  = pra_pkg::COORD_WIDTH_DEF;
   localparam int STAGES   = pra_pkg::CORDIC_STAGES_DEF;
   localparam int ANGLE_W  = pra_pkg::ANGLE_WIDTH;

   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_BEATS   = 1450;
   localparam int DRAIN_CYCLES   = STAGES + 7 + 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SHOW_LIMIT     = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } rotated_type;

   // one request beat; typed rows carry their answer, the rest use the model
   typedef struct {
      coord_type point_x;
      coord_type point_y;
      coord_type pivot_x;
      coord_type pivot_y;
      angle_type angle;
      bit        typed;
      coord_type exp_x;
      coord_type exp_y;
   } rot_req_type;

   localparam coord_type C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_type C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // angles in 1/64 degree
   localparam angle_type ANG_ZERO = '0;
   localparam angle_type ANG_45   = 16'sd2880;
   localparam angle_type ANG_90   = 16'sd5760;
   localparam angle_type ANG_90P  = 16'sd5761;
   localparam angle_type ANG_180  = 16'sd11520;
   localparam angle_type ANG_360  = 16'sd23040;
   localparam angle_type ANG_MAX  = 16'sh7FFF;
   localparam angle_type ANG_MIN  = 16'sh8000;
   localparam angle_type ANG_ONE  = 16'sd1;

   // fixed-point model constants
   localparam int     GUARD_BITS   = 36 - COORD_W;
   localparam int     GAIN_SHIFT   = 24 + GUARD_BITS;
   localparam longint GAIN_CORR    = 64'sd10188014;
   localparam longint ROUND_HALF   = 64'sd1 <<< (GAIN_SHIFT - 1);
   localparam longint BANG_TURN    = 64'sd1 <<< 32;
   localparam longint BANG_HALF    = 64'sd1 <<< 31;
   localparam longint BANG_QUARTER = 64'sd1 <<< 30;
   localparam longint UNITS_TURN   = 64'sd23040;
   localparam longint UNITS_HALF   = 64'sd11520;

   // atan(2^-i) as binary angles, full turn = 2^32
   localparam longint ARCTAN_TURN [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   localparam int DIRECTED_ROWS = 23;

   // directed table: point x/y, pivot x/y, angle, typed flag, typed x/y
   rot_req_type directed_tbl [DIRECTED_ROWS] = '{
      // zero angle passes the point through, coordinates at the rails
      '{C_MAX, C_MIN, 24'sd0, 24'sd0, ANG_ZERO, 1'b1, C_MAX, C_MIN},
      '{C_MIN, C_MAX, C_MAX, C_MIN, ANG_ZERO, 1'b1, C_MIN, C_MAX},
      // point sitting on the pivot comes back unchanged for any angle
      '{C_MIN, C_MIN, C_MIN, C_MIN, 16'sd5000, 1'b1, C_MIN, C_MIN},
      '{C_MAX, C_MAX, C_MAX, C_MAX, ANG_MIN, 1'b1, C_MAX, C_MAX},
      '{24'sd1234, -24'sd77, 24'sd1234, -24'sd77, ANG_MAX, 1'b1, 24'sd1234, -24'sd77},
      // quarter and half turns, and the fold boundary just past the quarter turns
      '{24'sd256, 24'sd0, 24'sd0, 24'sd0, ANG_90, 1'b0, 24'sd0, 24'sd0},
      '{24'sd256, 24'sd0, 24'sd0, 24'sd0, -ANG_90, 1'b0, 24'sd0, 24'sd0},
      '{24'sd256, 24'sd0, 24'sd0, 24'sd0, ANG_90P, 1'b0, 24'sd0, 24'sd0},
      '{24'sd256, 24'sd0, 24'sd0, 24'sd0, -ANG_90P, 1'b0, 24'sd0, 24'sd0},
      '{24'sd256, 24'sd0, 24'sd0, 24'sd0, ANG_180, 1'b0, 24'sd0, 24'sd0},
      '{24'sd0, 24'sd256, 24'sd0, 24'sd0, -ANG_180, 1'b0, 24'sd0, 24'sd0},
      // full turn and beyond wrap around
      '{24'sd1000, 24'sd2000, -24'sd300, 24'sd400, ANG_360, 1'b0, 24'sd0, 24'sd0},
      '{24'sd1000, 24'sd2000, -24'sd300, 24'sd400, -ANG_360, 1'b0, 24'sd0, 24'sd0},
      '{24'sd1000, 24'sd2000, -24'sd300, 24'sd400, ANG_MAX, 1'b0, 24'sd0, 24'sd0},
      '{24'sd1000, 24'sd2000, -24'sd300, 24'sd400, ANG_MIN, 1'b0, 24'sd0, 24'sd0},
      // smallest nonzero angles
      '{24'sd512, 24'sd512, 24'sd0, 24'sd0, ANG_ONE, 1'b0, 24'sd0, 24'sd0},
      '{24'sd512, 24'sd512, 24'sd0, 24'sd0, -ANG_ONE, 1'b0, 24'sd0, 24'sd0},
      // results driven off the coordinate range on either side
      '{C_MAX, 24'sd0, C_MIN, 24'sd0, ANG_180, 1'b0, 24'sd0, 24'sd0},
      '{C_MIN, 24'sd0, C_MAX, 24'sd0, ANG_180, 1'b0, 24'sd0, 24'sd0},
      '{C_MAX, C_MAX, C_MIN, C_MIN, ANG_90, 1'b0, 24'sd0, 24'sd0},
      '{C_MIN, C_MIN, C_MAX, C_MAX, -ANG_45, 1'b0, 24'sd0, 24'sd0},
      // a point matching its pivot in one coordinate or in neither is an ordinary rotation
      '{24'sd5000, 24'sd77, 24'sd5000, -24'sd77, ANG_90, 1'b0, 24'sd0, 24'sd0},
      '{-24'sd1, -24'sd1, 24'sd0, 24'sd0, -ANG_90, 1'b0, 24'sd0, 24'sd0}
   };

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   coord_type req_point_x = '0;
   coord_type req_point_y = '0;
   coord_type req_pivot_x = '0;
   coord_type req_pivot_y = '0;
   angle_type req_angle_deg = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   coord_type rsp_rotated_x;
   coord_type rsp_rotated_y;

   // side info that travels with the beat on the request ports
   bit        drive_typed = 1'b0;
   coord_type drive_exp_x = '0;
   coord_type drive_exp_y = '0;

   rotated_type pending_rotations [$];

   int fail_count      = 0;
   int shown_count     = 0;
   int idle_cycles     = 0;
   int results_checked = 0;
   int unchanged_count = 0;
   int railed_count    = 0;

   point_rotate_about_origin_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_pivot_x   (req_pivot_x),
      .req_pivot_y   (req_pivot_y),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rotated_x (rsp_rotated_x),
      .rsp_rotated_y (rsp_rotated_y)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   function automatic coord_type clamp_coord(longint v);
      if (v > longint'(C_MAX)) return C_MAX;
      if (v < longint'(C_MIN)) return C_MIN;
      return coord_type'(v);
   endfunction

   // rotation of the point about the pivot, bit exact with the block
   function automatic rotated_type rotate_about_pivot(coord_type px, coord_type py,
                                                      coord_type ox, coord_type oy,
                                                      angle_type ang);
      rotated_type r;
      longint      x, y, z, xs, ys, mag, q;
      // degenerate inputs pass straight through
      if ((px == ox && py == oy) || ang == ANG_ZERO) begin
         r.x = px;
         r.y = py;
         return r;
      end
      // 1/64 degree to binary angle, rounded half away from zero, wrapped
      mag = (ang < 0) ? -longint'(ang) : longint'(ang);
      q = (mag * BANG_TURN + UNITS_HALF) / UNITS_TURN;
      if (ang < 0) q = -q;
      z = longint'(int'(q));
      x = (longint'(px) - longint'(ox)) <<< GUARD_BITS;
      y = (longint'(py) - longint'(oy)) <<< GUARD_BITS;
      // fold into +-90 degrees by negating the vector
      if (z > BANG_QUARTER) begin
         z = z - BANG_HALF;
         x = -x;
         y = -y;
      end else if (z < -BANG_QUARTER) begin
         z = z + BANG_HALF;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - ARCTAN_TURN[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + ARCTAN_TURN[i];
         end
      end
      x = (x * GAIN_CORR + ROUND_HALF) >>> GAIN_SHIFT;
      y = (y * GAIN_CORR + ROUND_HALF) >>> GAIN_SHIFT;
      r.x = clamp_coord(x + longint'(ox));
      r.y = clamp_coord(y + longint'(oy));
      return r;
   endfunction

   function automatic coord_type rail_coord();
      case ($urandom_range(0, 4))
         0: return C_MAX;
         1: return C_MIN;
         2: return coord_type'(1);
         3: return coord_type'(-1);
         default: return '0;
      endcase
   endfunction

   // random beat: mostly points near their pivot, plus rails and full range
   function automatic rot_req_type random_rotation_job();
      rot_req_type j;
      int          pick, spread;
      longint      dx, dy;
      pick = $urandom_range(0, 99);
      j.pivot_x = coord_type'($urandom());
      j.pivot_y = coord_type'($urandom());
      j.typed = 1'b0;
      j.exp_x = '0;
      j.exp_y = '0;
      if (pick < 5) begin
         j.point_x = j.pivot_x;
         j.point_y = j.pivot_y;
      end else if (pick < 55) begin
         spread = $urandom_range(0, 16);
         dx = longint'($urandom_range(0, 2 << spread)) - (64'sd1 <<< spread);
         dy = longint'($urandom_range(0, 2 << spread)) - (64'sd1 <<< spread);
         j.point_x = coord_type'(longint'(j.pivot_x) + dx);
         j.point_y = coord_type'(longint'(j.pivot_y) + dy);
      end else if (pick < 80) begin
         j.point_x = coord_type'($urandom());
         j.point_y = coord_type'($urandom());
      end else begin
         j.point_x = rail_coord();
         j.point_y = rail_coord();
         j.pivot_x = rail_coord();
         j.pivot_y = rail_coord();
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         j.angle = ANG_ZERO;
      end else if (pick < 60) begin
         j.angle = angle_type'(int'($urandom_range(0, 46080)) - 23040);
      end else if (pick < 75) begin
         j.angle = angle_type'($urandom());
      end else if (pick < 90) begin
         // around the quarter-turn fold points
         j.angle = angle_type'((int'($urandom_range(0, 8)) - 4) * 5760
                               + int'($urandom_range(0, 2)) - 1);
      end else begin
         j.angle = angle_type'(int'($urandom_range(0, 128)) - 64);
      end
      return j;
   endfunction

   // request-side idle: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // present one beat after an optional gap and hold it until taken
   task automatic send_beat(input rot_req_type job, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_point_x   <= job.point_x;
      req_point_y   <= job.point_y;
      req_pivot_x   <= job.pivot_x;
      req_pivot_y   <= job.pivot_y;
      req_angle_deg <= job.angle;
      drive_typed   <= job.typed;
      drive_exp_x   <= job.exp_x;
      drive_exp_y   <= job.exp_y;
      do @(posedge clock); while (req_stall);
   endtask

   // result-side stall: runs of free cycles, short stalls, rare long stalls
   initial begin : result_sink
      int r, free_len, stall_len;
      forever begin
         r = $urandom_range(0, 99);
         free_len = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 6);
         r = $urandom_range(0, 99);
         stall_len = (r < 6) ? $urandom_range(20, 60) :
                     (r < 50) ? $urandom_range(1, 3) : 0;
         repeat (free_len) begin
            @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat (stall_len) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // scoreboard: results are checked before the new request is queued, so a
   // beat accepted on both sides in one cycle is ordered the same every time
   always @(posedge clock) begin : scoreboard
      rotated_type want;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            results_checked++;
            if (pending_rotations.size() == 0) begin
               fail_count++;
               if (shown_count < SHOW_LIMIT) begin
                  shown_count++;
                  $display("unexpected result beat: x %0d y %0d",
                           rsp_rotated_x, rsp_rotated_y);
               end
            end else begin
               want = pending_rotations.pop_front();
               if (want.x == C_MAX || want.x == C_MIN || want.y == C_MAX
                   || want.y == C_MIN) begin
                  railed_count++;
               end
               if (rsp_rotated_x !== want.x || rsp_rotated_y !== want.y) begin
                  fail_count++;
                  if (shown_count < SHOW_LIMIT) begin
                     shown_count++;
                     $display("mismatch on result %0d: x exp %0d got %0d, y exp %0d got %0d",
                              results_checked, want.x, rsp_rotated_x,
                              want.y, rsp_rotated_y);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            if ((req_point_x == req_pivot_x && req_point_y == req_pivot_y)
                || req_angle_deg == ANG_ZERO) begin
               unchanged_count++;
            end
            if (drive_typed) begin
               want.x = drive_exp_x;
               want.y = drive_exp_y;
            end else begin
               want = rotate_about_pivot(req_point_x, req_point_y, req_pivot_x,
                                         req_pivot_y, req_angle_deg);
            end
            pending_rotations.push_back(want);
         end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
   end

   // no beat on either side for too long means the block is stuck
   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no beat moved for %0d cycles, %0d results still owed",
               WATCHDOG_LIMIT, pending_rotations.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int gap;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows, with a little idling between them
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_beat(directed_tbl[i], idle_gap());
      end

      // random beats; every so often a stretch goes back to back
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         gap = ((n % 160) < 40) ? 0 : idle_gap();
         send_beat(random_rotation_job(), gap);
      end
      req_valid <= 1'b0;

      // let the pipeline drain, then watch a while for stray results
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d directed and %0d random beats, checked %0d results",
               DIRECTED_ROWS, RANDOM_BEATS, results_checked);
      $display("%0d passed through unchanged, %0d reached a coordinate rail",
               unchanged_count, railed_count);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
